// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Each check is disabled while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/sdspi_pkg.sv
package sdspi_pkg;

    localparam int BLOCK_BYTES = 512;
    localparam int BC_W        = $clog2(BLOCK_BYTES + 1);
    localparam int POLL_W      = 17;
    localparam int RPOLL_W     = 9;
    localparam int CFG_W       = 17;

    localparam logic [1:0] CFG_RESPONSE_POLL = 2'd0;
    localparam logic [1:0] CFG_TOKEN_POLL    = 2'd1;
    localparam logic [1:0] CFG_BUSY_POLL     = 2'd2;

    localparam logic [RPOLL_W-1:0] RESPONSE_POLL_RESET = 9'd256;
    localparam logic [POLL_W-1:0]  TOKEN_POLL_RESET    = 17'd65536;
    localparam logic [POLL_W-1:0]  BUSY_POLL_RESET     = 17'd65536;

    localparam logic [5:0] CMD_READ_SINGLE  = 6'd17;
    localparam logic [5:0] CMD_WRITE_SINGLE = 6'd24;
    localparam logic [5:0] CMD_ERASE_START  = 6'd32;
    localparam logic [5:0] CMD_ERASE_END    = 6'd33;
    localparam logic [5:0] CMD_ERASE        = 6'd38;

    localparam logic [7:0] BYTE_FILL     = 8'hFF;
    localparam logic [7:0] BYTE_TOKEN    = 8'hFE;
    localparam logic [7:0] BYTE_CRC      = 8'h95;
    localparam logic [4:0] DRESP_MASKED  = 5'h05;
    localparam logic [1:0] CMD_PREFIX    = 2'b01;

    localparam logic [1:0] ERASE_STEP_START = 2'd0;
    localparam logic [1:0] ERASE_STEP_END   = 2'd1;
    localparam logic [1:0] ERASE_STEP_LAST  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_R1_ERROR = 2'd1;
    localparam logic [1:0] ST_REJECTED = 2'd2;
    localparam logic [1:0] ST_TIMEOUT  = 2'd3;

    typedef enum logic [1:0] {
        OP_RAW   = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2,
        OP_ERASE = 2'd3
    } op_t;

    typedef enum logic [16:0] {
        PH_IDLE       = 17'h00001,
        PH_CMD_FRAME  = 17'h00002,
        PH_CMD_POLL   = 17'h00004,
        PH_CMD_EXTRA  = 17'h00008,
        PH_CMD_DESEL  = 17'h00010,
        PH_TOKEN_POLL = 17'h00020,
        PH_RD_DATA    = 17'h00040,
        PH_RD_TAIL    = 17'h00080,
        PH_WR_TOKEN   = 17'h00100,
        PH_WR_DATA    = 17'h00200,
        PH_WR_CRC     = 17'h00400,
        PH_WR_RESP    = 17'h00800,
        PH_BUSY1      = 17'h01000,
        PH_GAP_DESEL  = 17'h02000,
        PH_GAP_FREE   = 17'h04000,
        PH_BUSY2      = 17'h08000,
        PH_END_DESEL  = 17'h10000
    } phase_t;

    typedef struct packed {
        logic        req_type;
        op_t         operation;
        logic [22:0] block_address;
        logic [23:0] block_count;
        logic [5:0]  command_index;
        logic [31:0] command_argument;
        logic [7:0]  miso_byte;
        logic [7:0]  write_byte;
    } in_item_t;

    typedef struct packed {
        logic       exchange;
        logic [7:0] mosi_byte;
        logic       select_active;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       want_write_byte;
        logic       done_res;
        logic [1:0] status;
        logic [7:0] response_byte;
    } res_t;

    // A poll limit of zero behaves as a limit of one.
    function automatic logic [POLL_W-1:0] poll_limit(input logic [POLL_W-1:0] v);
        return (v == '0) ? POLL_W'(1) : v;
    endfunction

    function automatic logic [7:0] frame_byte(input logic [5:0]  cmd,
                                              input logic [31:0] arg,
                                              input logic [2:0]  idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = {CMD_PREFIX, cmd};
            3'd1:    b = arg[31:24];
            3'd2:    b = arg[23:16];
            3'd3:    b = arg[15:8];
            3'd4:    b = arg[7:0];
            default: b = BYTE_CRC;
        endcase
        return b;
    endfunction

endpackage

// File: rtl/sdspi_in_stage.sv
module sdspi_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [103:0]        s_tdata,
    input  logic                s_tuser,
    input  logic                advance,
    output logic                item_valid,
    output sdspi_pkg::in_item_t item
);

    logic                valid_reg;
    logic                valid_next;
    sdspi_pkg::in_item_t item_reg;
    sdspi_pkg::in_item_t item_next;
    logic                take;

    assign s_tready = !valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    always_comb begin
        item_next                  = item_reg;
        valid_next                 = valid_reg && !advance;
        if (take) begin
            valid_next                 = 1'b1;
            item_next.req_type         = s_tuser;
            item_next.operation        = sdspi_pkg::op_t'(s_tdata[1:0]);
            item_next.block_address    = s_tdata[24:2];
            item_next.block_count      = s_tdata[48:25];
            item_next.command_index    = s_tdata[54:49];
            item_next.command_argument = s_tdata[86:55];
            item_next.miso_byte        = s_tdata[94:87];
            item_next.write_byte       = s_tdata[102:95];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: rtl/sdspi_step.sv
module sdspi_step (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_wr_index,
    input  logic [16:0]         cfg_wr_data,
    input  logic                advance,
    input  sdspi_pkg::in_item_t item,
    output logic                has_res,
    output sdspi_pkg::res_t     res
);

    localparam int BC_W   = sdspi_pkg::BC_W;
    localparam int POLL_W = sdspi_pkg::POLL_W;

    logic [sdspi_pkg::RPOLL_W-1:0] resp_poll_max_reg;
    logic [POLL_W-1:0]             token_poll_max_reg;
    logic [POLL_W-1:0]             busy_poll_max_reg;

    sdspi_pkg::phase_t phase_reg, phase_next;
    sdspi_pkg::op_t    cur_op_reg, cur_op_next;
    logic [1:0]        erase_step_reg, erase_step_next;
    logic [BC_W-1:0]   byte_cnt_reg, byte_cnt_next;
    logic [POLL_W-1:0] poll_cnt_reg, poll_cnt_next;
    logic [31:0]       frame_arg_reg, frame_arg_next;
    logic [31:0]       end_arg_reg, end_arg_next;
    logic [5:0]        frame_cmd_reg, frame_cmd_next;
    logic [7:0]        held_resp_reg, held_resp_next;
    logic [1:0]        held_st_reg, held_st_next;

    logic [BC_W-1:0]   bc_inc;
    logic [BC_W:0]     bc_inc2;
    logic [POLL_W-1:0] poll_inc;
    logic [POLL_W-1:0] resp_lim;
    logic [POLL_W-1:0] token_lim;
    logic [POLL_W-1:0] busy_lim;
    logic [31:0]       end_sum;
    logic              st_go;
    logic [5:0]        st_cmd;
    logic [31:0]       st_arg;

    assign bc_inc    = byte_cnt_reg + BC_W'(1);
    assign bc_inc2   = {1'b0, bc_inc} + (BC_W + 1)'(1);
    assign poll_inc  = poll_cnt_reg + POLL_W'(1);
    assign resp_lim  = sdspi_pkg::poll_limit({8'd0, resp_poll_max_reg});
    assign token_lim = sdspi_pkg::poll_limit(token_poll_max_reg);
    assign busy_lim  = sdspi_pkg::poll_limit(busy_poll_max_reg);
    assign end_sum   = {9'd0, item.block_address} + {8'd0, item.block_count} - 32'd1;

    always_comb begin
        phase_next      = phase_reg;
        cur_op_next     = cur_op_reg;
        erase_step_next = erase_step_reg;
        byte_cnt_next   = byte_cnt_reg;
        poll_cnt_next   = poll_cnt_reg;
        frame_arg_next  = frame_arg_reg;
        end_arg_next    = end_arg_reg;
        frame_cmd_next  = frame_cmd_reg;
        held_resp_next  = held_resp_reg;
        held_st_next    = held_st_reg;
        res             = '0;
        has_res         = 1'b1;
        st_go           = 1'b0;
        st_cmd          = '0;
        st_arg          = '0;

        if (!item.req_type) begin
            // A start always wins, dropping whatever was in progress.
            cur_op_next     = item.operation;
            erase_step_next = sdspi_pkg::ERASE_STEP_START;
            held_resp_next  = '0;
            held_st_next    = sdspi_pkg::ST_OK;
            poll_cnt_next   = '0;
            st_go           = 1'b1;
            case (item.operation)
                sdspi_pkg::OP_RAW: begin
                    st_cmd = item.command_index;
                    st_arg = item.command_argument;
                end
                sdspi_pkg::OP_READ: begin
                    st_cmd = sdspi_pkg::CMD_READ_SINGLE;
                    st_arg = {item.block_address, 9'd0};
                end
                sdspi_pkg::OP_WRITE: begin
                    st_cmd = sdspi_pkg::CMD_WRITE_SINGLE;
                    st_arg = {item.block_address, 9'd0};
                end
                default: begin
                    st_cmd       = sdspi_pkg::CMD_ERASE_START;
                    st_arg       = {item.block_address, 9'd0};
                    end_arg_next = {end_sum[22:0], 9'd0};
                end
            endcase
        end else begin
            res.exchange      = 1'b1;
            res.mosi_byte     = sdspi_pkg::BYTE_FILL;
            res.select_active = 1'b1;
            case (phase_reg)
                sdspi_pkg::PH_CMD_FRAME: begin
                    byte_cnt_next = bc_inc;
                    if (bc_inc < BC_W'(6)) begin
                        res.mosi_byte = sdspi_pkg::frame_byte(frame_cmd_reg, frame_arg_reg,
                                                              bc_inc[2:0]);
                    end else begin
                        phase_next    = sdspi_pkg::PH_CMD_POLL;
                        poll_cnt_next = '0;
                    end
                end
                sdspi_pkg::PH_CMD_POLL: begin
                    if (item.miso_byte == sdspi_pkg::BYTE_FILL) begin
                        poll_cnt_next = poll_inc;
                    end
                    if (item.miso_byte != sdspi_pkg::BYTE_FILL || poll_inc >= resp_lim) begin
                        held_resp_next = item.miso_byte;
                        phase_next     = sdspi_pkg::PH_CMD_EXTRA;
                    end
                end
                sdspi_pkg::PH_CMD_EXTRA: begin
                    phase_next = sdspi_pkg::PH_CMD_DESEL;
                end
                sdspi_pkg::PH_CMD_DESEL: begin
                    if (held_resp_reg == sdspi_pkg::BYTE_FILL) begin
                        res.done_res      = 1'b1;
                        res.status        = sdspi_pkg::ST_TIMEOUT;
                        res.response_byte = (cur_op_reg == sdspi_pkg::OP_RAW) ?
                                            sdspi_pkg::BYTE_FILL : 8'd0;
                    end else if (held_resp_reg != 8'd0) begin
                        res.done_res      = 1'b1;
                        res.status        = sdspi_pkg::ST_R1_ERROR;
                        res.response_byte = held_resp_reg;
                    end else begin
                        case (cur_op_reg)
                            sdspi_pkg::OP_RAW: begin
                                res.done_res = 1'b1;
                            end
                            sdspi_pkg::OP_READ: begin
                                phase_next    = sdspi_pkg::PH_TOKEN_POLL;
                                poll_cnt_next = '0;
                            end
                            sdspi_pkg::OP_WRITE: begin
                                phase_next          = sdspi_pkg::PH_WR_TOKEN;
                                res.mosi_byte       = sdspi_pkg::BYTE_TOKEN;
                                res.want_write_byte = 1'b1;
                            end
                            default: begin
                                if (erase_step_reg == sdspi_pkg::ERASE_STEP_START) begin
                                    erase_step_next = sdspi_pkg::ERASE_STEP_END;
                                    st_go           = 1'b1;
                                    st_cmd          = sdspi_pkg::CMD_ERASE_END;
                                    st_arg          = end_arg_reg;
                                end else if (erase_step_reg == sdspi_pkg::ERASE_STEP_END) begin
                                    erase_step_next = sdspi_pkg::ERASE_STEP_LAST;
                                    st_go           = 1'b1;
                                    st_cmd          = sdspi_pkg::CMD_ERASE;
                                    st_arg          = '0;
                                end else begin
                                    res.done_res = 1'b1;
                                end
                            end
                        endcase
                    end
                end
                sdspi_pkg::PH_TOKEN_POLL: begin
                    if (item.miso_byte == sdspi_pkg::BYTE_TOKEN) begin
                        phase_next    = sdspi_pkg::PH_RD_DATA;
                        byte_cnt_next = '0;
                    end else begin
                        poll_cnt_next = poll_inc;
                        if (poll_inc >= token_lim) begin
                            phase_next     = sdspi_pkg::PH_END_DESEL;
                            held_st_next   = sdspi_pkg::ST_TIMEOUT;
                            held_resp_next = '0;
                        end
                    end
                end
                sdspi_pkg::PH_RD_DATA: begin
                    res.read_byte  = item.miso_byte;
                    res.read_valid = 1'b1;
                    byte_cnt_next  = bc_inc;
                    if (bc_inc >= BC_W'(sdspi_pkg::BLOCK_BYTES)) begin
                        phase_next    = sdspi_pkg::PH_RD_TAIL;
                        byte_cnt_next = '0;
                    end
                end
                sdspi_pkg::PH_RD_TAIL: begin
                    byte_cnt_next = bc_inc;
                    if (bc_inc >= BC_W'(4)) begin
                        res.done_res = 1'b1;
                    end
                end
                sdspi_pkg::PH_WR_TOKEN: begin
                    phase_next          = sdspi_pkg::PH_WR_DATA;
                    byte_cnt_next       = '0;
                    res.mosi_byte       = item.write_byte;
                    res.want_write_byte = (sdspi_pkg::BLOCK_BYTES > 1);
                end
                sdspi_pkg::PH_WR_DATA: begin
                    byte_cnt_next = bc_inc;
                    if (bc_inc < BC_W'(sdspi_pkg::BLOCK_BYTES)) begin
                        res.mosi_byte       = item.write_byte;
                        res.want_write_byte = bc_inc2 < (BC_W + 1)'(sdspi_pkg::BLOCK_BYTES);
                    end else begin
                        phase_next    = sdspi_pkg::PH_WR_CRC;
                        byte_cnt_next = '0;
                    end
                end
                sdspi_pkg::PH_WR_CRC: begin
                    byte_cnt_next = bc_inc;
                    if (bc_inc >= BC_W'(2)) begin
                        phase_next = sdspi_pkg::PH_WR_RESP;
                    end
                end
                sdspi_pkg::PH_WR_RESP: begin
                    if (item.miso_byte[4:0] != sdspi_pkg::DRESP_MASKED) begin
                        phase_next     = sdspi_pkg::PH_END_DESEL;
                        held_st_next   = sdspi_pkg::ST_REJECTED;
                        held_resp_next = item.miso_byte;
                    end else begin
                        phase_next    = sdspi_pkg::PH_BUSY1;
                        poll_cnt_next = '0;
                    end
                end
                sdspi_pkg::PH_BUSY1, sdspi_pkg::PH_BUSY2: begin
                    // Both busy waits draw on one shared poll budget.
                    if (item.miso_byte == 8'd0) begin
                        poll_cnt_next = poll_inc;
                        if (poll_inc >= busy_lim) begin
                            phase_next     = sdspi_pkg::PH_END_DESEL;
                            held_st_next   = sdspi_pkg::ST_TIMEOUT;
                            held_resp_next = '0;
                        end
                    end else if (phase_reg == sdspi_pkg::PH_BUSY1) begin
                        phase_next = sdspi_pkg::PH_GAP_DESEL;
                    end else begin
                        phase_next     = sdspi_pkg::PH_END_DESEL;
                        held_st_next   = sdspi_pkg::ST_OK;
                        held_resp_next = '0;
                    end
                end
                sdspi_pkg::PH_GAP_DESEL: begin
                    phase_next        = sdspi_pkg::PH_GAP_FREE;
                    res.select_active = 1'b0;
                end
                sdspi_pkg::PH_GAP_FREE: begin
                    phase_next = sdspi_pkg::PH_BUSY2;
                end
                sdspi_pkg::PH_END_DESEL: begin
                    res.done_res      = 1'b1;
                    res.status        = held_st_reg;
                    res.response_byte = held_resp_reg;
                end
                default: begin
                    // A completion word with nothing running produces no result.
                    phase_next = sdspi_pkg::PH_IDLE;
                    has_res    = 1'b0;
                    res        = '0;
                end
            endcase
            if (res.done_res) begin
                phase_next        = sdspi_pkg::PH_IDLE;
                res.exchange      = 1'b0;
                res.mosi_byte     = '0;
                res.select_active = 1'b0;
            end
        end

        if (st_go) begin
            frame_cmd_next    = st_cmd;
            frame_arg_next    = st_arg;
            byte_cnt_next     = '0;
            phase_next        = sdspi_pkg::PH_CMD_FRAME;
            res               = '0;
            res.exchange      = 1'b1;
            res.select_active = 1'b1;
            res.mosi_byte     = {sdspi_pkg::CMD_PREFIX, st_cmd};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            resp_poll_max_reg  <= sdspi_pkg::RESPONSE_POLL_RESET;
            token_poll_max_reg <= sdspi_pkg::TOKEN_POLL_RESET;
            busy_poll_max_reg  <= sdspi_pkg::BUSY_POLL_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                sdspi_pkg::CFG_RESPONSE_POLL: resp_poll_max_reg  <= cfg_wr_data[8:0];
                sdspi_pkg::CFG_TOKEN_POLL:    token_poll_max_reg <= cfg_wr_data;
                sdspi_pkg::CFG_BUSY_POLL:     busy_poll_max_reg  <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= sdspi_pkg::PH_IDLE;
            cur_op_reg     <= sdspi_pkg::OP_RAW;
            erase_step_reg <= '0;
            byte_cnt_reg   <= '0;
            poll_cnt_reg   <= '0;
            frame_arg_reg  <= '0;
            end_arg_reg    <= '0;
            frame_cmd_reg  <= '0;
            held_resp_reg  <= '0;
            held_st_reg    <= '0;
        end else if (advance) begin
            phase_reg      <= phase_next;
            cur_op_reg     <= cur_op_next;
            erase_step_reg <= erase_step_next;
            byte_cnt_reg   <= byte_cnt_next;
            poll_cnt_reg   <= poll_cnt_next;
            frame_arg_reg  <= frame_arg_next;
            end_arg_reg    <= end_arg_next;
            frame_cmd_reg  <= frame_cmd_next;
            held_resp_reg  <= held_resp_next;
            held_st_reg    <= held_st_next;
        end
    end

endmodule

// File: rtl/sdspi_out_stage.sv
module sdspi_out_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            advance,
    input  logic            has_res,
    input  sdspi_pkg::res_t res,
    input  logic            m_tready,
    output logic            res_valid,
    output sdspi_pkg::res_t res_out
);

    logic            valid_reg;
    logic            valid_next;
    sdspi_pkg::res_t res_reg;
    logic            load;

    assign load = advance && has_res;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign res_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

// File: rtl/sd_spi_block_transaction_engine_top.sv
// Channel   Direction  Ports                              Contents
// input     slave      s_tvalid s_tready s_tdata s_tuser  start request or exchange completion
// result    master     m_tvalid m_tready m_tdata m_tlast  next exchange request or done status
// config    write      cfg_wr_en cfg_wr_index cfg_wr_data poll limits
//
// Each word is worked on by sdspi_step while it sits in the input register; its result enters
// the output register at the edge on which the word leaves the input register. One word a cycle
// while m_tready does not stall the output, as set by the single state update per word in sdspi_step.
// Reset (aresetn low, synchronous) empties both registers and returns the sequencer to idle.
// A stall on m_tready holds the result; the input register still takes one more word if it is empty.
// A completion word arriving while idle is consumed and yields no result.
`include "assert_macros.svh"

module sd_spi_block_transaction_engine_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_wr_index,
    input  logic [16:0]  cfg_wr_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // operation, block_address, block_count, command_index, command_argument,
    // miso_byte, write_byte, one zero pad bit
    input  logic [103:0] s_tdata,
    // req_type
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // exchange, mosi_byte, select_active, read_byte, read_valid, want_write_byte,
    // status, response_byte, two zero pad bits
    output logic [31:0]  m_tdata,
    // done_res
    output logic         m_tlast
);

    logic                item_valid;
    sdspi_pkg::in_item_t item;
    logic                advance;
    logic                has_res;
    sdspi_pkg::res_t     res;
    sdspi_pkg::res_t     res_out;

    assign advance = item_valid && (!m_tvalid || m_tready);

    sdspi_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    sdspi_step u_step (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .advance      (advance),
        .item         (item),
        .has_res      (has_res),
        .res          (res)
    );

    sdspi_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .has_res   (has_res),
        .res       (res),
        .m_tready  (m_tready),
        .res_valid (m_tvalid),
        .res_out   (res_out)
    );

    assign m_tdata = {2'b00, res_out.response_byte, res_out.status, res_out.want_write_byte,
                      res_out.read_valid, res_out.read_byte, res_out.select_active,
                      res_out.mosi_byte, res_out.exchange};
    assign m_tlast = res_out.done_res;

    // A finished operation never asks for another exchange.
    `ASSERT_IMPLY(a_done_no_exchange, aclk, aresetn, m_tvalid && m_tlast, !m_tdata[0])
    // Read data only comes back alongside a selected exchange.
    `ASSERT_IMPLY(a_read_selected, aclk, aresetn, m_tvalid && m_tdata[18],
                  m_tdata[0] && m_tdata[9])
    // The input side only backs up when a result is stuck at the output.
    `ASSERT_IMPLY(a_stall_cause, aclk, aresetn, !s_tready,
                  item_valid && m_tvalid && !m_tready)
    // A word held back by a stall is still there in the next cycle.
    `ASSERT_NEXT(a_item_kept, aclk, aresetn, item_valid && !advance, item_valid)

endmodule
